### design/ffha_pkg.sv
// Package: constants, table entry type and state codes for the heap allocator.
package ffha_pkg;
  localparam int HeapBytes = 4194304;
  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam int OffW = $clog2(HeapBytes);
  localparam int SizeW = $clog2(HeapBytes);
  localparam logic [31:0] HeapBase = 32'h0040_0000;
  localparam logic [SizeW-1:0] HdrBytes = SizeW'(16);
  localparam logic [SizeW-1:0] SplitSlack = SizeW'(16);

  localparam logic [1:0] StatDone = 2'd0;
  localparam logic [1:0] StatNoFit = 2'd1;
  localparam logic [1:0] StatIgnored = 2'd2;

  localparam logic CmdAlloc = 1'b0;

  typedef struct packed {
    logic [OffW-1:0] off;
    logic [SizeW-1:0] size;
    logic used;
  } blk_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_NXT_RD,
    ST_NXT_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_OUT
  } state_t;
endpackage

### design/first_fit_heap_allocator_unit.sv
// Top level: first-fit heap allocator with split and forward merge over one table RAM.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, req_size, free_addr | into block
//  out     | out_valid, out_stall, alloc_addr, status,   | out of block
//          | used_bytes                                |
//
// Flow: each item walks the table one entry at a time (RAM read then check), then on a
// split or merge shifts entries one at a time, each a read then a write. The shift starts
// where the walk stopped, so together they cover the table once. The walk and the shift
// both go through the single table read port.
// Reset: the table entry 0 and count/used total are set by reset; other entries are
// never read before they are written, so no clearing pass is needed.
// Stalls: one item is in flight; the result holds in the output register while
// out_stall is high, and in_stall is high from accept until that beat is taken.
module first_fit_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [22:0] req_size,
  input  logic [31:0] free_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] alloc_addr,
  output logic [1:0]  status,
  output logic [21:0] used_bytes
);
  import ffha_pkg::*;

  // Table RAM, one read and one write port, registered read.
  blk_t mem [MaxBlocks];
  blk_t rd_data;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  blk_t wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Entry 0 shadow: after reset entry 0 reads from this until first write.
  logic e0_init;
  blk_t rd_blk;
  logic rd_was0;

  state_t state, state_next;
  logic [CntW-1:0] count, count_next;
  logic [21:0] used_total, used_total_next;
  logic [CntW-1:0] idx, idx_next;
  logic [CntW-1:0] k, k_next;
  logic op_cmd;
  logic [SizeW:0] op_req;
  logic [31:0] op_addr;
  blk_t cur, cur_next;
  blk_t ins, ins_next;
  logic [31:0] res_addr, res_addr_next;
  logic [1:0] res_stat, res_stat_next;

  always_comb begin
    rd_blk = rd_data;
    if (rd_was0 && e0_init) begin
      rd_blk.off = '0;
      rd_blk.size = SizeW'(HeapBytes - 16);
      rd_blk.used = 1'b0;
    end
  end

  logic [31:0] blk_ptr;
  logic [SizeW+1:0] split_lim;
  assign blk_ptr = HeapBase + 32'(rd_blk.off) + 32'(HdrBytes);
  assign split_lim = (SizeW+2)'(op_req) + (SizeW+2)'(HdrBytes) + (SizeW+2)'(SplitSlack);

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign alloc_addr = res_addr;
  assign status = res_stat;
  assign used_bytes = used_total;

  always_comb begin
    state_next = state;
    count_next = count;
    used_total_next = used_total;
    idx_next = idx;
    k_next = k;
    cur_next = cur;
    ins_next = ins;
    res_addr_next = res_addr;
    res_stat_next = res_stat;
    rd_addr = idx[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = idx[IdxW-1:0];
    wr_data = cur;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (in_valid) begin
          res_addr_next = '0;
          res_stat_next = (cmd == CmdAlloc) ? StatNoFit : StatIgnored;
          state_next = (cmd != CmdAlloc && free_addr == '0) ? ST_OUT : ST_RD;
        end
      end
      ST_RD: begin
        // Issue read of entry idx; stop at end of table.
        if (idx >= count) state_next = ST_OUT;
        else state_next = ST_CHK;
      end
      ST_CHK: begin
        cur_next = rd_blk;
        if (op_cmd == CmdAlloc) begin
          if (!rd_blk.used && {1'b0, rd_blk.size} >= op_req) begin
            cur_next.used = 1'b1;
            res_stat_next = StatDone;
            res_addr_next = blk_ptr;
            if ((SizeW+2)'(rd_blk.size) > split_lim && count < CntW'(MaxBlocks)) begin
              cur_next.size = op_req[SizeW-1:0];
              ins_next.off = rd_blk.off + OffW'(HdrBytes) + OffW'(op_req);
              ins_next.size = rd_blk.size - op_req[SizeW-1:0] - HdrBytes;
              ins_next.used = 1'b0;
              used_total_next = used_total + 22'(op_req);
              k_next = count;
              count_next = count + 1'b1;
              state_next = ST_SH_RD;
            end else begin
              used_total_next = used_total + 22'(rd_blk.size);
              wr_en = 1'b1;
              wr_data = cur_next;
              state_next = ST_OUT;
            end
          end else begin
            idx_next = idx + 1'b1;
            state_next = ST_RD;
          end
        end else begin
          if (blk_ptr == op_addr) begin
            res_stat_next = StatDone;
            if (rd_blk.used) used_total_next = used_total - 22'(rd_blk.size);
            cur_next.used = 1'b0;
            wr_en = 1'b1;
            wr_data = cur_next;
            state_next = ST_NXT_RD;
          end else begin
            idx_next = idx + 1'b1;
            state_next = ST_RD;
          end
        end
      end
      // Shift entries [idx+1, count-1) up by one, top first.
      ST_SH_RD: begin
        if (k == idx + 1'b1) begin
          wr_en = 1'b1;
          wr_addr = k[IdxW-1:0];
          wr_data = ins;
          state_next = ST_SH_WR;
        end else begin
          rd_addr = IdxW'(k - 1'b1);
          state_next = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        if (k == idx + 1'b1) begin
          wr_en = 1'b1;
          wr_data = cur;
          state_next = ST_OUT;
        end else begin
          wr_en = 1'b1;
          wr_addr = k[IdxW-1:0];
          wr_data = rd_blk;
          k_next = k - 1'b1;
          state_next = ST_SH_RD;
        end
      end
      ST_NXT_RD: begin
        rd_addr = IdxW'(idx + 1'b1);
        if (idx + 1'b1 >= count) state_next = ST_OUT;
        else state_next = ST_NXT_CHK;
      end
      ST_NXT_CHK: begin
        if (!rd_blk.used) begin
          cur_next.size = cur.size + HdrBytes + rd_blk.size;
          wr_en = 1'b1;
          wr_data = cur_next;
          k_next = idx + 1'b1;
          state_next = ST_RM_RD;
        end else begin
          state_next = ST_OUT;
        end
      end
      // Shift entries above k down by one.
      ST_RM_RD: begin
        rd_addr = IdxW'(k + 1'b1);
        if (k + 1'b1 >= count) begin
          count_next = count - 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_RM_WR;
        end
      end
      ST_RM_WR: begin
        wr_en = 1'b1;
        wr_addr = k[IdxW-1:0];
        wr_data = rd_blk;
        k_next = k + 1'b1;
        state_next = ST_RM_RD;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= CntW'(1);
      used_total <= '0;
      e0_init <= 1'b1;
    end else begin
      state <= state_next;
      count <= count_next;
      used_total <= used_total_next;
      if (wr_en && wr_addr == '0) e0_init <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_was0 <= (rd_addr == '0);
    idx <= idx_next;
    k <= k_next;
    cur <= cur_next;
    ins <= ins_next;
    res_addr <= res_addr_next;
    res_stat <= res_stat_next;
    if (state == ST_IDLE && in_valid) begin
      op_cmd <= cmd;
      op_req <= (SizeW+1)'(req_size);
      op_addr <= free_addr;
    end
  end
endmodule

### dv/testbench.sv
// Testbench: drives directed and random alloc/free beats into the heap allocator and checks every result.
module testbench;
  import ffha_pkg::*;

  localparam int NumRandom = 1262;
  localparam logic CmdFree = 1'b1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [22:0] req_size;
  logic [31:0] free_addr;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] alloc_addr;
  logic [1:0]  status;
  logic [21:0] used_bytes;

  first_fit_heap_allocator_unit uut (.*);

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  stat;
    logic [21:0] used;
  } heap_result_t;

  // Shadow heap table and the queue of predicted results.
  class heap_scoreboard;
    logic [31:0] offs[MaxBlocks];
    logic [31:0] sizes[MaxBlocks];
    bit          busy[MaxBlocks];
    int          count;
    logic [31:0] used_sum;
    heap_result_t pending[$];
    int errors;

    function new();
      count = 1;
      offs[0] = 0;
      sizes[0] = HeapBytes - 16;
      busy[0] = 0;
      used_sum = 0;
      errors = 0;
    endfunction

    // Predict the result of one accepted command beat.
    function void note_command(logic c, logic [22:0] rq, logic [31:0] fa);
      heap_result_t r;
      int i;
      int k;
      r.addr = 0;
      if (c == CmdAlloc) begin
        r.stat = StatNoFit;
        for (i = 0; i < count; i++) begin
          if (!busy[i] && sizes[i] >= rq) begin
            if (sizes[i] > rq + 32 && count < MaxBlocks) begin
              for (k = count; k > i + 1; k--) begin
                offs[k] = offs[k-1]; sizes[k] = sizes[k-1]; busy[k] = busy[k-1];
              end
              offs[i+1] = offs[i] + 16 + rq;
              sizes[i+1] = sizes[i] - rq - 16;
              busy[i+1] = 0;
              count++;
              sizes[i] = rq;
            end
            busy[i] = 1;
            used_sum += sizes[i];
            r.addr = HeapBase + offs[i] + 16;
            r.stat = StatDone;
            break;
          end
        end
      end else begin
        r.stat = StatIgnored;
        if (fa != 0) begin
          for (i = 0; i < count; i++) begin
            if (HeapBase + offs[i] + 16 == fa) begin
              if (busy[i]) begin
                used_sum -= sizes[i];
                busy[i] = 0;
              end
              // Forward merge only.
              if (i + 1 < count && !busy[i+1]) begin
                sizes[i] += 16 + sizes[i+1];
                for (k = i + 1; k + 1 < count; k++) begin
                  offs[k] = offs[k+1]; sizes[k] = sizes[k+1]; busy[k] = busy[k+1];
                end
                count--;
              end
              r.stat = StatDone;
              break;
            end
          end
        end
      end
      r.used = used_sum[21:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] a, logic [1:0] s, logic [21:0] u);
      heap_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result addr=%h status=%0d used=%0d", a, s, u);
        return;
      end
      e = pending.pop_front();
      if (e.addr !== a || e.stat !== s || e.used !== u) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp addr=%h status=%0d used=%0d, got addr=%h status=%0d used=%0d",
                   e.addr, e.stat, e.used, a, s, u);
      end
    endfunction

    // Pick a live block start, something near one, or a random address as a free target.
    function logic [31:0] pick_addr();
      int j;
      j = $urandom_range(0, count - 1);
      case ($urandom_range(0, 9))
        0: return $urandom();
        1: return HeapBase + offs[j] + 16 + $urandom_range(1, 8);
        default: return HeapBase + offs[j] + 16;
      endcase
    endfunction
  endclass

  heap_scoreboard sb;
  int burst_left;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver stall pattern: switch between calm and busy phases.
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(alloc_addr, status, used_bytes);
  end

  // Drive one beat and hold it until accepted; drop valid only for gaps between bursts.
  task automatic send_beat(logic c, logic [22:0] rq, logic [31:0] fa);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    cmd <= c;
    req_size <= rq;
    free_addr <= fa;
    do @(posedge clk); while (in_stall);
    sb.note_command(c, rq, fa);
  endtask

  function automatic logic [22:0] rand_size();
    case ($urandom_range(0, 19))
      0: return 23'($urandom());
      1: return 23'($urandom_range(4194270, 4194304));
      2: return 23'($urandom_range(0, 40));
      default: return 23'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int n;
    int waitc;
    sb = new();
    burst_left = 0;
    rst = 1;
    in_valid = 0;
    cmd = 0;
    req_size = 0;
    free_addr = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero size, tiny, exact fit edges, oversize, ignored frees.
    send_beat(CmdAlloc, 0, 0);
    send_beat(CmdAlloc, 23'h7FFFFF, 32'hFFFFFFFF);
    send_beat(CmdAlloc, 4194304, 0);
    send_beat(CmdAlloc, 32, 0);
    send_beat(CmdAlloc, 100, 0);
    send_beat(CmdFree, 0, 0);
    send_beat(CmdFree, 0, 32'hFFFFFFFF);
    send_beat(CmdFree, 0, HeapBase + 17);
    send_beat(CmdFree, 0, HeapBase + 16);          // first block, next block used
    send_beat(CmdFree, 0, HeapBase + 16);          // free of a free block
    send_beat(CmdFree, 0, HeapBase + 16 + 16);     // frees the 32-byte block, next block used
    send_beat(CmdAlloc, 48, 0);                    // skips the two small free blocks, splits the tail
    send_beat(CmdAlloc, 4194304 - 400, 0);         // large request, still fits the tail and splits it
    // Fill the table to force unsplit hand-out.
    for (n = 0; n < 70; n++) send_beat(CmdAlloc, 23'($urandom_range(0, 64)), 0);
    send_beat(CmdAlloc, 0, 0);
    for (n = 0; n < 40; n++) send_beat(CmdFree, 0, sb.pick_addr());

    for (n = 0; n < NumRandom; n++) begin
      if ($urandom_range(0, 99) < ((sb.count > 50) ? 35 : 55))
        send_beat(CmdAlloc, rand_size(), $urandom());
      else
        send_beat(CmdFree, 23'($urandom()), sb.pick_addr());
    end
    // Free the first block repeatedly, merging forward into it whenever the next block is free.
    for (n = 0; n < 64; n++) send_beat(CmdFree, 0, HeapBase + sb.offs[0] + 16);
    in_valid <= 0;

    waitc = 0;
    while (sb.pending.size() != 0 && waitc < 200000) begin
      @(posedge clk);
      waitc++;
    end
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #100000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
